// ----- sv/bce_pkg.sv -----
// Package: constants and discharge curve tables for the battery charge estimator.
`default_nettype none

package bce_pkg;

    localparam int PACK_W    = 14;
    localparam int CELL_W    = 13;
    localparam int PCT_W     = 7;
    localparam int DELTA_W   = 9;   // widest segment is 300 mV
    localparam int FACTOR_W  = 14;
    localparam int FRAC_W    = 16;  // reciprocal scale, 2^16
    localparam int SEG_N     = 7;
    localparam int SEG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;

    localparam logic [CELL_W-1:0] CELL_MAX_MV    = 13'd4200;
    localparam logic [CELL_W-1:0] CELL_MIN_MV    = 13'd3000;
    localparam logic [CELL_W-1:0] ABSENT_CELL_MV = 13'd3850;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_PRESENT = 2'd2;

    localparam logic [PCT_W-1:0] LOW_THRESHOLD_RST  = 7'd20;
    localparam logic [PCT_W-1:0] CRIT_THRESHOLD_RST = 7'd5;

    // Segment i spans SEG_LO_MV[i] .. next breakpoint up.
    localparam logic [CELL_W-1:0] SEG_LO_MV [SEG_N] =
        '{13'd4000, 13'd3850, 13'd3700, 13'd3600, 13'd3500, 13'd3300, 13'd3000};
    localparam logic [PCT_W-1:0] SEG_BASE_PCT [SEG_N] =
        '{7'd90, 7'd70, 7'd50, 7'd30, 7'd15, 7'd5, 7'd0};
    // ceil(2^16 * span_pct / span_mv); error stays under 1/denominator for d <= 300
    localparam logic [FACTOR_W-1:0] SEG_FACTOR [SEG_N] =
        '{14'd3277, 14'd8739, 14'd8739, 14'd13108, 14'd9831, 14'd3277, 14'd1093};

endpackage

`default_nettype wire

// ----- sv/battery_charge_estimator.sv -----
// Top level: four-stage pipelined state-of-charge estimator for a 2S pack.
//
//  channel | direction | words                                         | handshake
//  s_      | in        | pack_millivolts, charge_active                | s_valid / s_ready
//  m_      | out       | cell_millivolts, charge_percent, low/crit/chg | m_valid / m_ready
//  cfg_    | in        | cfg_index, cfg_wdata                          | cfg_wen, no wait
//
// One word per cycle while m_ready stays high; m_valid is the stage 4 valid bit.
// Stages: cell voltage select, clamp and segment lookup, reciprocal multiply,
// final add with threshold compare into the output register.
// Each stage holds when its successor is full and stalled; bubbles get squeezed out.
// aresetn (synchronous) clears the valid bits and restores the register defaults.
`default_nettype none

module battery_charge_estimator
    import bce_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [PACK_W-1:0]    s_pack_millivolts,
    input  wire logic                 s_charge_active,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [CELL_W-1:0]         m_cell_millivolts,
    output logic [PCT_W-1:0]          m_charge_percent,
    output logic                      m_low_flag,
    output logic                      m_critical_flag,
    output logic                      m_charging_flag
);

    // ---------------- configuration registers ----------------
    logic [PCT_W-1:0] low_thr_reg;
    logic [PCT_W-1:0] crit_thr_reg;
    logic             sensor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg  <= LOW_THRESHOLD_RST;
            crit_thr_reg <= CRIT_THRESHOLD_RST;
            sensor_reg   <= 1'b1;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_wdata;
                REG_CRIT_THRESHOLD: crit_thr_reg <= cfg_wdata;
                REG_SENSOR_PRESENT: sensor_reg   <= cfg_wdata[0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // ---------------- pipeline registers ----------------
    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    logic                       rdy1, rdy2, rdy3, rdy4;

    logic [CELL_W-1:0]          cell1_reg, cell2_reg, cell3_reg;
    logic                       chg1_reg, chg2_reg, chg3_reg;

    logic [DELTA_W-1:0]         delta2_reg;
    logic [FACTOR_W-1:0]        factor2_reg;
    logic [PCT_W-1:0]           base2_reg, base3_reg;

    logic [PCT_W-1:0]           inc3_reg;

    logic [CELL_W-1:0]          cell4_reg;
    logic [PCT_W-1:0]           pct4_reg;
    logic                       low4_reg, crit4_reg, chg4_reg;

    // A stage may load when empty or when its contents move on this cycle.
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // ---------------- stage 1: cell voltage ----------------
    logic [CELL_W-1:0] cell1_next;
    assign cell1_next = sensor_reg ? s_pack_millivolts[PACK_W-1:1] : ABSENT_CELL_MV;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            cell1_reg <= cell1_next;
            chg1_reg  <= s_charge_active;
        end
    end

    // ---------------- stage 2: clamp and segment pick ----------------
    logic [CELL_W-1:0]  clamp_mv;
    logic [SEG_W-1:0]   seg_sel;
    logic [CELL_W-1:0]  delta_full;
    logic [DELTA_W-1:0] delta2_next;

    always_comb begin
        if (cell1_reg > CELL_MAX_MV) begin
            clamp_mv = CELL_MAX_MV;
        end else if (cell1_reg < CELL_MIN_MV) begin
            clamp_mv = CELL_MIN_MV;
        end else begin
            clamp_mv = cell1_reg;
        end
        // highest segment whose lower breakpoint is at or below the voltage
        seg_sel = SEG_W'(SEG_N - 1);
        for (int i = SEG_N - 1; i >= 0; i--) begin
            if (clamp_mv >= SEG_LO_MV[i]) begin
                seg_sel = SEG_W'(i);
            end
        end
        delta_full  = clamp_mv - SEG_LO_MV[seg_sel];
        delta2_next = delta_full[DELTA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            cell2_reg   <= cell1_reg;
            chg2_reg    <= chg1_reg;
            delta2_reg  <= delta2_next;
            factor2_reg <= SEG_FACTOR[seg_sel];
            base2_reg   <= SEG_BASE_PCT[seg_sel];
        end
    end

    // ---------------- stage 3: scaled increment ----------------
    logic [DELTA_W+FACTOR_W-1:0] prod;
    assign prod = DELTA_W'(delta2_reg) * factor2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            cell3_reg <= cell2_reg;
            chg3_reg  <= chg2_reg;
            base3_reg <= base2_reg;
            inc3_reg  <= prod[FRAC_W +: PCT_W];
        end
    end

    // ---------------- stage 4: percent and flags ----------------
    logic [PCT_W-1:0] pct4_next;
    assign pct4_next = base3_reg + inc3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            cell4_reg <= cell3_reg;
            chg4_reg  <= chg3_reg;
            pct4_reg  <= pct4_next;
            low4_reg  <= (pct4_next <= low_thr_reg);
            crit4_reg <= (pct4_next <= crit_thr_reg);
        end
    end

    assign m_valid           = v4_reg;
    assign m_cell_millivolts = cell4_reg;
    assign m_charge_percent  = pct4_reg;
    assign m_low_flag        = low4_reg;
    assign m_critical_flag   = crit4_reg;
    assign m_charging_flag   = chg4_reg;

`ifndef SYNTH
    // percent never leaves the curve's range
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_charge_percent <= 7'd100))
        else $error("charge_percent above 100");

    // clamped top end reads full
    a_top_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_cell_millivolts >= CELL_MAX_MV)) |-> (m_charge_percent == 7'd100))
        else $error("cell at or above max but percent not 100");

    // clamped bottom end reads empty
    a_bottom_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_cell_millivolts <= CELL_MIN_MV)) |-> (m_charge_percent == 7'd0))
        else $error("cell at or below min but percent not 0");

    // a held mid-pipe word keeps its payload
    a_stage2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(delta2_reg) && $stable(base2_reg)))
        else $error("stage 2 word changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking bench for battery_charge_estimator: predictor, driver, monitor, stimulus.
module testbench
    import bce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run limits and curve constants
    // ------------------------------------------------------------------
    localparam int CLK_HALF   = 10;       // 20 ns period
    localparam int CYCLE_CAP  = 400000;   // hard stop for a hung run
    localparam int LONG_STALL = 300;      // receiver hold-off, far longer than the pipe
    localparam int PHASE_WORDS = 240;
    localparam int DRAIN_CYCLES = 16;     // pipe is four deep, leave slack

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it

    // discharge curve, top breakpoint first
    localparam int KNEE_MV  [8] = '{4200, 4000, 3850, 3700, 3600, 3500, 3300, 3000};
    localparam int KNEE_PCT [8] = '{100, 90, 70, 50, 30, 15, 5, 0};
    localparam int TOP_MV     = 4200;
    localparam int BOTTOM_MV  = 3000;
    localparam int NOSENSE_MV = 3850;     // fixed cell voltage with no monitor fitted

    typedef struct packed {
        logic [PACK_W-1:0] pack;
        logic              chg;
    } sample_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_v;
        logic [PCT_W-1:0]  pct;
        logic              low;
        logic              crit;
        logic              chg;
    } soc_t;

    // ------------------------------------------------------------------
    // DUT connections, inputs at known values from time zero
    // ------------------------------------------------------------------
    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PACK_W-1:0]    s_pack_millivolts = '0;
    logic                 s_charge_active   = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [CELL_W-1:0]    m_cell_millivolts;
    logic [PCT_W-1:0]     m_charge_percent;
    logic                 m_low_flag;
    logic                 m_critical_flag;
    logic                 m_charging_flag;

    battery_charge_estimator uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pack_millivolts (s_pack_millivolts),
        .s_charge_active   (s_charge_active),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cell_millivolts (m_cell_millivolts),
        .m_charge_percent  (m_charge_percent),
        .m_low_flag        (m_low_flag),
        .m_critical_flag   (m_critical_flag),
        .m_charging_flag   (m_charging_flag)
    );

    // ------------------------------------------------------------------
    // Shadow of the register file, as the block should hold it
    // ------------------------------------------------------------------
    logic [PCT_W-1:0] thr_low   = 7'd20;
    logic [PCT_W-1:0] thr_crit  = 7'd5;
    logic             sensor_on = 1'b1;

    sample_t pending_samples [$];   // words waiting for the driver
    soc_t    expected_soc    [$];   // estimates owed by the block, oldest first

    // pacing knobs, set per phase by the stimulus
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit long_stall_req   = 1'b0;
    bit long_stall_taken = 1'b0;

    int src_gap  = 0;
    int snk_hold = 0;
    int cycles   = 0;
    int errors   = 0;
    int words_taken = 0;
    int results_checked = 0;
    int full_seen = 0, empty_seen = 0, low_seen = 0, crit_seen = 0, nosense_seen = 0;
    int stall_backpressure = 0;     // cycles the input was refused during the long hold
    soc_t want_soc;

    // ------------------------------------------------------------------
    // Predictor: halve, clamp, interpolate on the curve, compare thresholds
    // ------------------------------------------------------------------
    function automatic soc_t estimate_soc(input logic [PACK_W-1:0] pack, input logic chg);
        soc_t r;
        int   mv;
        int   pct;
        int   k;
        bit   hit;
        mv = sensor_on ? int'(pack >> 1) : NOSENSE_MV;
        r.cell_v = mv[CELL_W-1:0];
        if (mv > TOP_MV) mv = TOP_MV;
        if (mv < BOTTOM_MV) mv = BOTTOM_MV;
        pct = 0;
        hit = 1'b0;
        // a breakpoint belongs to the segment above it
        for (k = 0; k < 7; k++) begin
            if (!hit && mv >= KNEE_MV[k+1]) begin
                hit = 1'b1;
                pct = KNEE_PCT[k+1] + ((mv - KNEE_MV[k+1]) * (KNEE_PCT[k] - KNEE_PCT[k+1]))
                      / (KNEE_MV[k] - KNEE_MV[k+1]);
            end
        end
        r.pct  = pct[PCT_W-1:0];
        r.low  = (r.pct <= thr_low);
        r.crit = (r.pct <= thr_crit);
        r.chg  = chg;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, and a hard stop if the run hangs
    // ------------------------------------------------------------------
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("battery_charge_estimator test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: offers words from pending_samples, predicts on each accept.
    // Valid is only touched when the slot is free, so it never drops
    // before its word is taken.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_soc.push_back(estimate_soc(s_pack_millivolts, s_charge_active));
                words_taken++;
                if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
                    src_gap = $urandom_range(1, 16);
            end
            if (long_stall_taken && snk_hold > 0 && s_valid && !s_ready)
                stall_backpressure++;
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    s_valid           <= 1'b1;
                    s_pack_millivolts <= pending_samples[0].pack;
                    s_charge_active   <= pending_samples[0].chg;
                    void'(pending_samples.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result word against the oldest estimate and
    // paces m_ready, including the one long hold-off.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_soc.size() == 0) begin
                    $error("unexpected result word: cell_millivolts %0d charge_percent %0d",
                           m_cell_millivolts, m_charge_percent);
                    errors++;
                end else begin
                    want_soc = expected_soc.pop_front();
                    results_checked++;
                    if (m_cell_millivolts !== want_soc.cell_v) begin
                        $error("cell_millivolts: expected %0d, got %0d",
                               want_soc.cell_v, m_cell_millivolts);
                        errors++;
                    end
                    if (m_charge_percent !== want_soc.pct) begin
                        $error("charge_percent: expected %0d, got %0d",
                               want_soc.pct, m_charge_percent);
                        errors++;
                    end
                    if (m_low_flag !== want_soc.low) begin
                        $error("low_flag: expected %0d, got %0d", want_soc.low, m_low_flag);
                        errors++;
                    end
                    if (m_critical_flag !== want_soc.crit) begin
                        $error("critical_flag: expected %0d, got %0d",
                               want_soc.crit, m_critical_flag);
                        errors++;
                    end
                    if (m_charging_flag !== want_soc.chg) begin
                        $error("charging_flag: expected %0d, got %0d",
                               want_soc.chg, m_charging_flag);
                        errors++;
                    end
                    if (want_soc.pct == 7'd100) full_seen++;
                    if (want_soc.pct == 7'd0) empty_seen++;
                    if (want_soc.low) low_seen++;
                    if (want_soc.crit) crit_seen++;
                    if (!sensor_on) nosense_seen++;
                end
            end
            if (long_stall_req && !long_stall_taken) begin
                long_stall_taken = 1'b1;
                snk_hold = LONG_STALL;
            end
            if (snk_hold > 0) begin
                snk_hold--;
                m_ready <= 1'b0;
            end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                snk_hold = $urandom_range(0, 15);   // this cycle is the first of the burst
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register writes, only issued with the pipe empty
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_LOW_THRESHOLD:  thr_low   = val;
            REG_CRIT_THRESHOLD: thr_crit  = val;
            REG_SENSOR_PRESENT: sensor_on = val[0];
            default: ;   // spare index, write dropped
        endcase
    endtask

    // every word handed out, accepted and answered
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_samples.size() != 0 || s_valid || expected_soc.size() != 0)
            @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    localparam int DIRECTED_N = 23;
    localparam int DIRECTED_PACK [DIRECTED_N] = '{
        0, 16383, 8400, 8401, 8402, 8000, 8001, 7700, 7701, 7400, 7200, 7000,
        6600, 6602, 6000, 6001, 5999, 5998, 8398, 1, 16382, 10922, 5461
    };

    sample_t smp;
    int ph, n, sel, cell_mv;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults: breakpoints, clamp edges, field extremes
        @(negedge aclk);
        src_idle_pct = 20;
        snk_idle_pct = 10;
        for (n = 0; n < DIRECTED_N; n++) begin
            smp.pack = DIRECTED_PACK[n][PACK_W-1:0];
            smp.chg  = n[0];
            pending_samples.push_back(smp);
        end

        for (ph = 0; ph < 8; ph++) begin
            wait_idle();
            src_idle_pct = $urandom_range(0, 40);
            snk_idle_pct = $urandom_range(0, 25);
            case (ph)
                0: begin
                    write_reg(REG_LOW_THRESHOLD, 7'd0);
                    write_reg(REG_CRIT_THRESHOLD, 7'd0);
                end
                1: begin
                    // past 100: flags stuck high
                    write_reg(REG_LOW_THRESHOLD, 7'd127);
                    write_reg(REG_CRIT_THRESHOLD, 7'd127);
                end
                2: begin
                    write_reg(REG_LOW_THRESHOLD, 7'd100);
                    write_reg(REG_CRIT_THRESHOLD, 7'd100);
                end
                3: begin
                    write_reg(REG_LOW_THRESHOLD, 7'($urandom_range(0, 127)));
                    write_reg(REG_CRIT_THRESHOLD, 7'($urandom_range(0, 127)));
                    // sender runs flat out against a long receiver hold-off
                    src_idle_pct = 0;
                    snk_idle_pct = 10;
                    long_stall_req = 1'b1;
                end
                4: begin
                    write_reg(REG_LOW_THRESHOLD, 7'd50);
                    write_reg(REG_CRIT_THRESHOLD, 7'd10);
                    write_reg(REG_SPARE, 7'h7F);
                end
                5: begin
                    // no monitor fitted; upper data bits must be ignored
                    write_reg(REG_SENSOR_PRESENT, 7'h7E);
                    write_reg(REG_LOW_THRESHOLD, 7'($urandom_range(0, 127)));
                    write_reg(REG_CRIT_THRESHOLD, 7'($urandom_range(0, 127)));
                end
                6: begin
                    write_reg(REG_SENSOR_PRESENT, 7'h7F);
                    write_reg(REG_LOW_THRESHOLD, 7'($urandom_range(0, 100)));
                    write_reg(REG_CRIT_THRESHOLD, 7'($urandom_range(0, 30)));
                end
                default: begin
                    // closing stretch: no idling anywhere
                    write_reg(REG_LOW_THRESHOLD, 7'($urandom_range(0, 127)));
                    write_reg(REG_CRIT_THRESHOLD, 7'($urandom_range(0, 127)));
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            @(negedge aclk);
            for (n = 0; n < PHASE_WORDS; n++) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    // mostly the live part of the curve, just past both clamps
                    cell_mv  = $urandom_range(2950, 4250);
                    smp.pack = PACK_W'(cell_mv * 2 + $urandom_range(0, 1));
                end else if (sel == 7) begin
                    smp.pack = PACK_W'(KNEE_MV[$urandom_range(0, 7)] * 2 + $urandom_range(0, 1));
                end else begin
                    smp.pack = PACK_W'($urandom_range(0, 16383));
                end
                smp.chg = 1'($urandom_range(0, 1));
                pending_samples.push_back(smp);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d words over 8 register settings plus reset defaults, %0d checked",
                 words_taken, results_checked);
        $display("full %0d, empty %0d, low %0d, critical %0d, sensorless %0d, stalled input %0d",
                 full_seen, empty_seen, low_seen, crit_seen, nosense_seen, stall_backpressure);
        if (errors == 0 && expected_soc.size() == 0)
            $display("battery_charge_estimator test passed");
        else
            $display("battery_charge_estimator test failed");
        $finish;
    end

endmodule
